// ----- hw/rtl/bwsc_pkg.sv -----
// Package: window size, sample and control types, status and register codes.
`timescale 1ns / 1ps
package bwsc_pkg;

  localparam int unsigned WINDOW = 16;
  localparam int unsigned IDX_W  = $clog2(WINDOW);
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  typedef struct packed {
    logic        [15:0] voltage;
    logic signed [15:0] current;
  } sample_t;

  typedef struct packed {
    logic load;    // take the first sample of a scan as min and max
    logic update;  // fold the next sample into min and max
  } scan_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    STS_STORED    = 3'd0,
    STS_FULL      = 3'd1,
    STS_EMPTY     = 3'd2,
    STS_CONVERT   = 3'd3,
    STS_DISABLED  = 3'd4,
    STS_CUR_RANGE = 3'd5,
    STS_NOT_FULL  = 3'd6,
    STS_UNSTABLE  = 3'd7
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE         = 3'd0,
    CFG_CUR_LOW        = 3'd1,
    CFG_CUR_HIGH       = 3'd2,
    CFG_VOLT_SPREAD    = 3'd3,
    CFG_CUR_SPREAD     = 3'd4,
    CFG_VOLT_FULL      = 3'd5,
    CFG_VOLT_EMPTY     = 3'd6,
    CFG_NOM_CAPACITY   = 3'd7
  } cfg_idx_t;

  localparam logic REQ_PUSH = 1'b0;

endpackage

// ----- hw/rtl/bwsc_if.sv -----
// Channel interfaces for requests and results.
`timescale 1ns / 1ps
interface bwsc_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic        [15:0] sample_voltage;
  logic signed [15:0] sample_current;

  modport source (output valid, req_type, sample_voltage, sample_current, input ready);
  modport sink   (input valid, req_type, sample_voltage, sample_current, output ready);
endinterface

interface bwsc_out_if;
  logic        valid;
  logic        ready;
  logic        success;
  logic [2:0]  status_code;
  logic [19:0] capacity;
  logic [15:0] voltage_spread;
  logic [15:0] current_spread;

  modport source (output valid, success, status_code, capacity, voltage_spread,
                  current_spread, input ready);
  modport sink   (input valid, success, status_code, capacity, voltage_spread,
                  current_spread, output ready);
endinterface

// ----- hw/rtl/bwsc_cell.sv -----
// One window cell: holds a sample and passes it on when the chain shifts.
`timescale 1ns / 1ps
module bwsc_cell
  import bwsc_pkg::*;
(
  input  logic    clk,
  input  logic    shift_en,
  input  sample_t data_in,
  output sample_t data_out
);

  sample_t held;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      held <= data_in;
    end
  end

  assign data_out = held;

endmodule

// ----- hw/rtl/bwsc_minmax.sv -----
// Running min and max of voltage and current over samples leaving the chain.
`timescale 1ns / 1ps
module bwsc_minmax
  import bwsc_pkg::*;
(
  input  logic               clk,
  input  scan_ctl_t          ctl,
  input  sample_t            sample,
  output logic        [15:0] vmin,
  output logic        [15:0] vmax,
  output logic signed [15:0] cmin,
  output logic signed [15:0] cmax
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      vmin <= sample.voltage;
      vmax <= sample.voltage;
      cmin <= sample.current;
      cmax <= sample.current;
    end else if (ctl.update) begin
      if (sample.voltage < vmin) vmin <= sample.voltage;
      if (sample.voltage > vmax) vmax <= sample.voltage;
      if (sample.current < cmin) cmin <= sample.current;
      if (sample.current > cmax) cmax <= sample.current;
    end
  end

endmodule

// ----- hw/rtl/battery_window_stability_check_core.sv -----
// Top level: config registers, sample chain, scan control and result register.
//
//  channel | dir | handshake     | payload
//  req     | in  | valid/ready   | req_type, sample_voltage, sample_current
//  rsp     | out | valid/ready   | success, status_code, capacity, spreads
//  cfg     | in  | cfg_wen       | cfg_index, cfg_data
//
// A push or a rejected request is answered straight from IDLE; an evaluation on a full
// window rotates the cell chain once through the single min/max unit, then the FINISH
// state forms spreads and the verdict.
// Synchronous reset clears control state and config; cell contents are not reset.
// A request is taken while idle and the result register is empty or draining.
`timescale 1ns / 1ps
module battery_window_stability_check_core
  import bwsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  bwsc_in_if.sink               req,
  bwsc_out_if.source            rsp,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic               enable;
  logic signed [15:0] cur_low;
  logic signed [15:0] cur_high;
  logic        [15:0] volt_spread_lim;
  logic        [15:0] cur_spread_lim;
  logic        [15:0] volt_full;
  logic        [15:0] volt_empty;
  logic        [19:0] nom_capacity;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable          <= 1'b0;
      cur_low         <= 16'sh8000;
      cur_high        <= 16'sh7FFF;
      volt_spread_lim <= '0;
      cur_spread_lim  <= '0;
      volt_full       <= 16'hFFFF;
      volt_empty      <= '0;
      nom_capacity    <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ENABLE:       enable          <= cfg_data[0];
        CFG_CUR_LOW:      cur_low         <= $signed(cfg_data[15:0]);
        CFG_CUR_HIGH:     cur_high        <= $signed(cfg_data[15:0]);
        CFG_VOLT_SPREAD:  volt_spread_lim <= cfg_data[15:0];
        CFG_CUR_SPREAD:   cur_spread_lim  <= cfg_data[15:0];
        CFG_VOLT_FULL:    volt_full       <= cfg_data[15:0];
        CFG_VOLT_EMPTY:   volt_empty      <= cfg_data[15:0];
        CFG_NOM_CAPACITY: nom_capacity    <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // control state
  state_t           state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] fill, fill_next;
  logic [15:0]      eval_volt;

  // result register
  logic        out_valid, out_valid_next;
  logic        out_success, out_success_next;
  status_t     out_status, out_status_next;
  logic [19:0] out_capacity, out_capacity_next;
  logic [15:0] out_vs, out_vs_next;
  logic [15:0] out_cs, out_cs_next;

  logic      rdy;
  logic      acc;
  logic      shift_en;
  logic      rotate;
  scan_ctl_t ctl;

  sample_t chain [WINDOW];
  sample_t head_in;
  sample_t new_sample;

  logic        [15:0] vmin, vmax;
  logic signed [15:0] cmin, cmax;
  logic        [15:0] vs;
  logic signed [16:0] cs_wide;
  logic        [15:0] cs;
  logic               cur_bad;

  assign new_sample.voltage = req.sample_voltage;
  assign new_sample.current = req.sample_current;
  assign head_in = rotate ? chain[WINDOW-1] : new_sample;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      bwsc_cell u_cell (.clk(clk), .shift_en(shift_en), .data_in(head_in),
                        .data_out(chain[i]));
    end else begin : g_body
      bwsc_cell u_cell (.clk(clk), .shift_en(shift_en), .data_in(chain[i-1]),
                        .data_out(chain[i]));
    end
  end

  bwsc_minmax u_minmax (
    .clk    (clk),
    .ctl    (ctl),
    .sample (chain[WINDOW-1]),
    .vmin   (vmin),
    .vmax   (vmax),
    .cmin   (cmin),
    .cmax   (cmax)
  );

  assign rdy     = (state == ST_IDLE) && (!out_valid || rsp.ready);
  assign acc     = req.valid && rdy;
  assign cur_bad = (req.sample_current < cur_low) || (req.sample_current > cur_high);

  assign vs      = vmax - vmin;
  assign cs_wide = {cmax[15], cmax} - {cmin[15], cmin};
  assign cs      = cs_wide[15:0];

  always_comb begin
    state_next        = state;
    cnt_next          = cnt;
    fill_next         = fill;
    shift_en          = 1'b0;
    rotate            = 1'b0;
    ctl               = '0;
    out_valid_next    = out_valid && !rsp.ready;
    out_success_next  = out_success;
    out_status_next   = out_status;
    out_capacity_next = out_capacity;
    out_vs_next       = out_vs;
    out_cs_next       = out_cs;

    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          out_valid_next    = 1'b1;
          out_success_next  = 1'b0;
          out_capacity_next = '0;
          out_vs_next       = '0;
          out_cs_next       = '0;
          priority if (!enable) begin
            out_status_next = STS_DISABLED;
          end else if (cur_bad) begin
            out_status_next = STS_CUR_RANGE;
          end else if (req.req_type == REQ_PUSH) begin
            out_success_next = 1'b1;
            out_status_next  = STS_STORED;
            shift_en         = 1'b1;
            if (fill != CNT_W'(WINDOW)) fill_next = fill + 1'b1;
          end else if (fill != CNT_W'(WINDOW)) begin
            out_status_next = STS_NOT_FULL;
          end else begin
            out_valid_next = 1'b0;
            cnt_next       = '0;
            state_next     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // rotate once round the ring, tail feeds the min/max unit
        shift_en   = 1'b1;
        rotate     = 1'b1;
        ctl.load   = (cnt == '0);
        ctl.update = (cnt != '0);
        cnt_next   = cnt + 1'b1;
        if (cnt == IDX_W'(WINDOW - 1)) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        out_valid_next    = 1'b1;
        out_vs_next       = vs;
        out_cs_next       = cs;
        out_capacity_next = '0;
        out_success_next  = 1'b1;
        priority if (vs > volt_spread_lim || cs > cur_spread_lim) begin
          out_success_next = 1'b0;
          out_status_next  = STS_UNSTABLE;
        end else if (eval_volt >= volt_full) begin
          out_status_next   = STS_FULL;
          out_capacity_next = nom_capacity;
        end else if (eval_volt <= volt_empty) begin
          out_status_next = STS_EMPTY;
        end else begin
          out_status_next = STS_CONVERT;
        end
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      fill      <= fill_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) eval_volt <= req.sample_voltage;
    out_success  <= out_success_next;
    out_status   <= out_status_next;
    out_capacity <= out_capacity_next;
    out_vs       <= out_vs_next;
    out_cs       <= out_cs_next;
  end

  assign req.ready          = rdy;
  assign rsp.valid          = out_valid;
  assign rsp.success        = out_success;
  assign rsp.status_code    = out_status;
  assign rsp.capacity       = out_capacity;
  assign rsp.voltage_spread = out_vs;
  assign rsp.current_spread = out_cs;

endmodule
